FILE: rtl/core/udrf_pkg.sv
// Shared types and constants for the upshift damp and rpm fade block.
package udrf_pkg;

   localparam int RPM_W  = 16;
   localparam int GEAR_W = 4;
   localparam int TS_W   = 32;
   localparam int CSR_W  = 2;
   localparam int REQ_W  = 56;
   localparam int RSP_W  = 24;

   localparam logic [CSR_W-1:0] CSR_DAMP_MS     = 2'd0;
   localparam logic [CSR_W-1:0] CSR_RAMP_LINKED = 2'd1;
   localparam logic [CSR_W-1:0] CSR_OUT_MAX     = 2'd2;

   localparam logic [RPM_W-1:0] RPM_FULL_SCALE = 16'hFFFF;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIV,
      ST_DAMP
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

endpackage

FILE: rtl/core/udrf_div.sv
// Restoring divider that yields a 16-bit quotient, one bit per cycle.
module udrf_div
   import udrf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [2*RPM_W-1:0]   dividend,
   input  logic [RPM_W-1:0]     divisor,
   output div_sts_type          sts,
   output logic [RPM_W-1:0]     quotient
);

   localparam int CNT_W = $clog2(RPM_W);

   logic [RPM_W-1:0] rem_ff, rem_in;
   logic [RPM_W-1:0] quo_ff, quo_in;
   logic [RPM_W-1:0] dsr_ff, dsr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [RPM_W:0]   shifted;
   logic [RPM_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[RPM_W-1]};
      diff    = shifted - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend[2*RPM_W-1:RPM_W];
         quo_in  = dividend[RPM_W-1:0];
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[RPM_W]) begin
            rem_in = diff[RPM_W-1:0];
            quo_in = {quo_ff[RPM_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[RPM_W-1:0];
            quo_in = {quo_ff[RPM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RPM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/upshift_damp_rpm_fade.sv
// Top level of the upshift damp and rpm fade block.
// An item passes from acceptance through the calc and damp states back to idle, and inside
// a damp window also through a div state, where the interpolation runs through a 16-step
// bit-serial divider; a new item is taken while the previous result waits in the output
// register, and its last step holds until that register is free.
module upshift_damp_rpm_fade
   import udrf_pkg::*;
#(
   parameter int TIME_BITS = 32
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // rpm [15:0], gear_now [19:16], now_ms [51:20], zero padding above.
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // faded_rpm [15:0], shifting [16], freeze_ramp [17], zero padding above.
   output logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CSR_W-1:0] csr_index,
   input  logic [RPM_W-1:0] csr_data
);

   state_type state_ff, state_in;

   logic [RPM_W-1:0]     damp_ms_ff;
   logic                 ramp_linked_ff;
   logic [RPM_W-1:0]     out_max_ff;

   logic [GEAR_W-1:0]    prev_gear_ff;
   logic [RPM_W-1:0]     last_rpm_ff;
   logic [RPM_W-1:0]     shift_rpm_ff;
   logic [TIME_BITS-1:0] window_start_ff;
   logic [TIME_BITS-1:0] window_end_ff;

   logic [RPM_W-1:0]     rpm_ff;
   logic [GEAR_W-1:0]    gear_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 up_ff;
   logic [RPM_W-1:0]     faded_ff, faded_in;

   logic                 rsp_valid_ff;
   logic [RPM_W-1:0]     rsp_faded_ff;
   logic                 rsp_shift_ff;
   logic                 rsp_freeze_ff;

   logic                    req_acc;
   logic                    out_free;
   logic [TIME_BITS+TS_W-1:0] now_wide;
   logic [TIME_BITS-1:0]    elapsed;
   logic [TIME_BITS-1:0]    damp_ext;
   logic                    in_window;
   logic [RPM_W-1:0]        rpm_diff;
   logic [2*RPM_W-1:0]      product;
   logic                    div_start;
   div_sts_type             div_sts;
   logic [RPM_W-1:0]        quotient;
   logic [RPM_W:0]          interp;
   logic                    upshift;
   logic [TIME_BITS-1:0]    end_sum;
   logic [TIME_BITS-1:0]    end_new;
   logic [TIME_BITS-1:0]    end_final;
   logic                    freeze;

   assign req_acc   = req_tvalid && req_tready;
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready = 1'b1;
   assign now_wide  = {{TIME_BITS{1'b0}}, req_tdata[51:20]};
   assign damp_ext  = {{(TIME_BITS-RPM_W){1'b0}}, damp_ms_ff};

   // Fade step arithmetic on the window state as it stood before this item.
   always_comb begin
      elapsed   = now_ff - window_start_ff;
      in_window = (window_end_ff != '0) && (damp_ms_ff != '0) && (elapsed < damp_ext);
      rpm_diff  = up_ff ? (rpm_ff - shift_rpm_ff) : (shift_rpm_ff - rpm_ff);
      product   = rpm_diff * elapsed[RPM_W-1:0];
      if (up_ff) begin
         interp = {1'b0, shift_rpm_ff} + {1'b0, quotient};
      end else begin
         interp = {1'b0, shift_rpm_ff} - {1'b0, quotient};
      end
      if (interp > {1'b0, out_max_ff}) begin
         faded_in = out_max_ff;
      end else begin
         faded_in = interp[RPM_W-1:0];
      end
   end

   // Damp step on the latched item.
   always_comb begin
      upshift   = ramp_linked_ff && (gear_ff > prev_gear_ff) && (prev_gear_ff != '0);
      end_sum   = now_ff + damp_ext;
      end_new   = upshift ? end_sum : window_end_ff;
      end_final = window_end_ff;
      freeze    = 1'b0;
      if (ramp_linked_ff) begin
         end_final = end_new;
         if (end_new != '0) begin
            if (now_ff >= end_new) begin
               end_final = '0;
            end else begin
               freeze = 1'b1;
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = in_window ? ST_DIV : ST_DAMP;
         end
         ST_DIV: begin
            if (!div_sts.busy) begin
               state_in = ST_DAMP;
            end
         end
         ST_DAMP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_CALC: div_start  = in_window;
         ST_DIV:  div_start  = 1'b0;
         ST_DAMP: div_start  = 1'b0;
         default: req_tready = 1'b0;
      endcase
   end

   udrf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (product),
      .divisor  (damp_ms_ff),
      .sts      (div_sts),
      .quotient (quotient)
   );

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rpm_ff  <= req_tdata[15:0];
         gear_ff <= req_tdata[19:16];
         now_ff  <= now_wide[TIME_BITS-1:0];
         up_ff   <= req_tdata[15:0] >= shift_rpm_ff;
      end
      if (state_ff == ST_CALC) begin
         faded_ff <= rpm_ff;
      end
      if ((state_ff == ST_DIV) && !div_sts.busy) begin
         faded_ff <= faded_in;
      end
      if ((state_ff == ST_DAMP) && out_free) begin
         rsp_faded_ff  <= faded_ff;
         rsp_shift_ff  <= end_final != '0;
         rsp_freeze_ff <= freeze;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         damp_ms_ff      <= '0;
         ramp_linked_ff  <= 1'b1;
         out_max_ff      <= RPM_FULL_SCALE;
         prev_gear_ff    <= '0;
         last_rpm_ff     <= '0;
         shift_rpm_ff    <= '0;
         window_start_ff <= '0;
         window_end_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            case (csr_index)
               CSR_DAMP_MS:     damp_ms_ff     <= csr_data;
               CSR_RAMP_LINKED: ramp_linked_ff <= csr_data[0];
               CSR_OUT_MAX:     out_max_ff     <= csr_data;
               default:         ;
            endcase
         end
         if (state_ff == ST_CALC) begin
            last_rpm_ff <= rpm_ff;
         end
         if ((state_ff == ST_DAMP) && out_free) begin
            rsp_valid_ff <= 1'b1;
            if (ramp_linked_ff) begin
               prev_gear_ff <= gear_ff;
            end
            if (upshift) begin
               shift_rpm_ff    <= last_rpm_ff;
               window_start_ff <= now_ff;
            end
            window_end_ff <= end_final;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-RPM_W-2){1'b0}}, rsp_freeze_ff, rsp_shift_ff, rsp_faded_ff};

endmodule

FILE: sim/tb.sv
// Self-checking testbench for the upshift damp and rpm fade block.
`timescale 1ns / 1ps

import udrf_pkg::*;

typedef struct packed {
   logic [RPM_W-1:0]  rpm;
   logic [GEAR_W-1:0] gear;
   logic [TS_W-1:0]   now;
} tick_type;

typedef struct packed {
   logic [RPM_W-1:0] rpm;
   logic             shifting;
   logic             freeze;
} fade_out_type;

class damp_scoreboard;
   logic [RPM_W-1:0]  damp_ms;
   logic              ramp_linked;
   logic [RPM_W-1:0]  out_max;
   logic [GEAR_W-1:0] prev_gear;
   logic [RPM_W-1:0]  last_rpm;
   logic [RPM_W-1:0]  shift_rpm;
   logic [TS_W-1:0]   win_start;
   logic [TS_W-1:0]   win_end;
   fade_out_type      due_outputs[$];
   int                mismatches;

   function new();
      damp_ms     = '0;
      ramp_linked = 1'b1;
      out_max     = RPM_FULL_SCALE;
      prev_gear   = '0;
      last_rpm    = '0;
      shift_rpm   = '0;
      win_start   = '0;
      win_end     = '0;
      mismatches  = 0;
   endfunction

   function void set_reg(logic [CSR_W-1:0] idx, logic [RPM_W-1:0] val);
      case (idx)
         CSR_DAMP_MS:     damp_ms = val;
         CSR_RAMP_LINKED: ramp_linked = val[0];
         CSR_OUT_MAX:     out_max = val;
         default: ;
      endcase
   endfunction

   // Fade on the window as it stood before the tick, then upshift detection.
   function void note_tick(tick_type t);
      fade_out_type     o;
      logic [TS_W-1:0]  elapsed;
      logic [RPM_W-1:0] diff;
      logic [63:0]      mag;
      logic [63:0]      v;
      last_rpm = t.rpm;
      o.rpm    = t.rpm;
      o.freeze = 1'b0;
      if (win_end != '0 && damp_ms != '0) begin
         elapsed = t.now - win_start;
         if (elapsed < {16'd0, damp_ms}) begin
            diff = (t.rpm >= shift_rpm) ? t.rpm - shift_rpm : shift_rpm - t.rpm;
            mag  = ({48'd0, diff} * {32'd0, elapsed}) / {48'd0, damp_ms};
            if (t.rpm >= shift_rpm) begin
               v = {48'd0, shift_rpm} + mag;
            end else begin
               v = {48'd0, shift_rpm} - mag;
            end
            if (v > {48'd0, out_max}) begin
               v = {48'd0, out_max};
            end
            o.rpm = v[RPM_W-1:0];
         end
      end
      if (ramp_linked) begin
         if (t.gear > prev_gear && prev_gear != '0) begin
            shift_rpm = last_rpm;
            win_start = t.now;
            win_end   = t.now + {16'd0, damp_ms};
         end
         if (win_end != '0) begin
            if (t.now >= win_end) begin
               win_end = '0;
            end else begin
               o.freeze = 1'b1;
            end
         end
         prev_gear = t.gear;
      end
      o.shifting = (win_end != '0);
      due_outputs.push_back(o);
   endfunction

   function void check_output(logic [RSP_W-1:0] d);
      fade_out_type e;
      if (due_outputs.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Unexpected output: rpm %0d shifting %0b freeze %0b",
                     d[15:0], d[16], d[17]);
         end
      end else begin
         e = due_outputs.pop_front();
         if (d[15:0] !== e.rpm || d[16] !== e.shifting || d[17] !== e.freeze) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Mismatch: expected rpm %0d shifting %0b freeze %0b, %s",
                        e.rpm, e.shifting, e.freeze,
                        $sformatf("got rpm %0d shifting %0b freeze %0b",
                                  d[15:0], d[16], d[17]));
            end
         end
      end
   endfunction
endclass

module tb;
   localparam int CYCLE_LIMIT = 500000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_index = '0;
   logic [RPM_W-1:0] csr_data = '0;

   damp_scoreboard board;
   tick_type       tick_q[$];
   int             ticks_in_flight = 0;
   int             cycle_count = 0;
   logic           calm = 1'b0;

   upshift_damp_rpm_fade i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 50) begin
         return 0;
      end else if (r < 85) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Request side: valid stays high across back-to-back items.
   initial begin : req_driver
      tick_type cur;
      int       gap;
      while (reset) @(posedge clock);
      forever begin
         if (tick_q.size() == 0) begin
            @(posedge clock);
         end else begin
            cur = tick_q.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {4'd0, cur.now, cur.gear, cur.rpm};
            do @(posedge clock); while (!req_tready);
            board.note_tick(cur);
            ticks_in_flight--;
            gap = pick_gap();
            if (gap > 0 || tick_q.size() == 0) begin
               req_tvalid <= 1'b0;
               repeat ((gap > 0) ? gap : 1) @(posedge clock);
            end
         end
      end
   end

   // Response side: random stalls, none in calm phases.
   initial begin : rsp_sink
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            board.check_output(rsp_tdata);
         end
         if (hold > 0) begin
            hold--;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            hold = pick_gap();
         end
         rsp_tready <= (hold == 0) && !reset;
      end
   end

   task automatic queue_tick(input logic [RPM_W-1:0] rpm, input logic [GEAR_W-1:0] gear,
                             input logic [TS_W-1:0] now);
      tick_type t;
      t.rpm  = rpm;
      t.gear = gear;
      t.now  = now;
      ticks_in_flight++;
      tick_q.push_back(t);
   endtask

   task automatic wait_drain();
      while (ticks_in_flight != 0 || board.due_outputs.size() != 0) @(posedge clock);
   endtask

   task automatic apply_config(input logic [RPM_W-1:0] damp, input logic linked,
                               input logic [RPM_W-1:0] omax);
      logic [CSR_W-1:0] idx;
      logic [RPM_W-1:0] val;
      for (int k = 0; k < 3; k++) begin
         case (k)
            0: begin
               idx = CSR_DAMP_MS;
               val = damp;
            end
            1: begin
               idx = CSR_RAMP_LINKED;
               val = {15'd0, linked};
            end
            default: begin
               idx = CSR_OUT_MAX;
               val = omax;
            end
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_data  <= val;
         do @(posedge clock); while (!csr_ready);
         board.set_reg(idx, val);
      end
      csr_valid <= 1'b0;
   endtask

   // Mostly plausible driving: advancing time, gear changes, rpm walks; some noise.
   task automatic queue_drive(input int count, input int damp);
      logic [TS_W-1:0]   tnow;
      logic [GEAR_W-1:0] g;
      int                rpm;
      int                span;
      int                r;
      span = (damp == 0) ? 20 : damp;
      tnow = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2 * span)
                                         : $urandom();
      g    = GEAR_W'($urandom_range(1, 3));
      rpm  = $urandom_range(0, 65535);
      repeat (count) begin
         if ($urandom_range(0, 6) == 0) begin
            queue_tick(RPM_W'($urandom_range(0, 65535)), GEAR_W'($urandom_range(0, 15)),
                       $urandom());
         end else begin
            r = $urandom_range(0, 9);
            if (r == 0) begin
               tnow = tnow;
            end else if (r < 8) begin
               tnow = tnow + $urandom_range(0, span / 5 + 1);
            end else if (r == 8) begin
               tnow = tnow + $urandom_range(0, span);
            end else begin
               tnow = tnow + $urandom_range(0, span * 3);
            end
            r = $urandom_range(0, 99);
            if (r < 25) begin
               g = (g > 13) ? 4'd15 : g + GEAR_W'($urandom_range(1, 2));
            end else if (r < 45) begin
               g = (g > 1) ? g - 1'b1 : g;
            end else if (r < 50) begin
               g = '0;
            end else if (g == '0) begin
               g = 4'd1;
            end
            if ($urandom_range(0, 4) < 3) begin
               rpm = rpm + int'($urandom_range(0, 4000)) - 2000;
               rpm = (rpm < 0) ? 0 : (rpm > 65535) ? 65535 : rpm;
            end else begin
               rpm = $urandom_range(0, 65535);
            end
            queue_tick(rpm[15:0], g, tnow);
         end
      end
   endtask

   initial begin : main
      int               r;
      logic [RPM_W-1:0] damp;
      logic             linked;
      logic [RPM_W-1:0] omax;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero damp time, an upshift opens and shuts at once.
      queue_tick(16'd0, 4'd0, 32'd0);
      queue_tick(16'hFFFF, 4'd15, 32'hFFFF_FFFF);
      queue_tick(16'd1234, 4'd1, 32'd10);
      queue_tick(16'd2000, 4'd2, 32'd11);
      wait_drain();

      // Fade up and down, a second upshift inside the window, window end, wrapping ends.
      apply_config(16'd100, 1'b1, 16'hFFFF);
      queue_tick(16'd3000, 4'd1, 32'd1000);
      queue_tick(16'd3000, 4'd2, 32'd1000);
      queue_tick(16'd5000, 4'd2, 32'd1050);
      queue_tick(16'd0, 4'd2, 32'd1075);
      queue_tick(16'hFFFF, 4'd3, 32'd1099);
      queue_tick(16'd100, 4'd3, 32'd1199);
      queue_tick(16'd7000, 4'd4, 32'hFFFF_FF9C);
      queue_tick(16'd7000, 4'd5, 32'hFFFF_FFCE);
      wait_drain();

      // Longest window with a low clamp; the window is left open.
      apply_config(16'hFFFF, 1'b1, 16'd2500);
      queue_tick(16'd1000, 4'd1, 32'd500);
      queue_tick(16'd1000, 4'd2, 32'd500);
      queue_tick(16'hFFFF, 4'd2, 32'd40000);
      queue_tick(16'd0, 4'd2, 32'd40001);
      wait_drain();

      // Damping unlinked: the open window still fades, upshifts are ignored.
      apply_config(16'hFFFF, 1'b0, 16'hFFFF);
      queue_tick(16'd30000, 4'd2, 32'd50000);
      queue_tick(16'd30000, 4'd3, 32'd50001);
      wait_drain();

      // One millisecond window, zero clamp, a repeated timestamp inside it.
      apply_config(16'd1, 1'b1, 16'd0);
      queue_tick(16'd500, 4'd4, 32'd50002);
      queue_tick(16'd9, 4'd4, 32'd50002);
      queue_tick(16'd9, 4'd4, 32'd50003);
      wait_drain();

      for (int p = 0; p < 8; p++) begin
         r = $urandom_range(0, 5);
         case (r)
            0: damp = 16'd0;
            1: damp = 16'd1;
            2: damp = 16'hFFFF;
            5: damp = RPM_W'($urandom_range(0, 65535));
            default: damp = RPM_W'($urandom_range(2, 400));
         endcase
         linked = ($urandom_range(0, 4) != 0);
         r = $urandom_range(0, 5);
         omax = (r == 0) ? 16'd0 : (r < 3) ? 16'($urandom_range(0, 65535)) : 16'hFFFF;
         apply_config(damp, linked, omax);
         calm = ($urandom_range(0, 3) == 0);
         queue_drive(55, int'(damp));
         wait_drain();
      end

      calm = 1'b0;
      repeat (40) @(posedge clock);
      if (board.due_outputs.size() != 0) begin
         board.mismatches++;
         $display("%0d expected outputs never arrived", board.due_outputs.size());
      end
      if (board.mismatches == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
